/* rtl/pps_pkg.sv */
// ----------------------------------------------------------------------------
// pps_pkg: shared types and constants of the projection sampler
// Item, configuration and pipeline tag types, field widths and codes.
// ----------------------------------------------------------------------------
package pps_pkg;

  localparam int FUNC_W     = 2;
  localparam int IDX_W      = 18;
  localparam int PIX_IN_W   = 16;
  localparam int WORD_W     = 32;
  localparam int DIM_W      = 10;
  localparam int FOCAL_W    = 31;
  localparam int OUT_IDX_W  = 9;
  localparam int CFG_IDX_W  = 3;
  localparam int NUM_COEFFS = 12;
  localparam int COEFF_IDX_W = 4;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [FUNC_W-1:0] FUNC_PIXEL   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_POSE    = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_PROJECT = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_U = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_V = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FOCAL    = 3'd4;

  localparam logic [DIM_W-1:0]   RST_WIDTH  = 10'd512;
  localparam logic [DIM_W-1:0]   RST_HEIGHT = 10'd512;
  localparam logic [FOCAL_W-1:0] RST_FOCAL  = 31'd65536;

  typedef enum logic [1:0] {
    OP_PIXEL,
    OP_POSE,
    OP_PROJECT
  } pps_op_e;

  typedef struct packed {
    pps_op_e                  op;
    logic [IDX_W-1:0]         idx;
    logic [PIX_IN_W-1:0]      pix;
    logic signed [WORD_W-1:0] coeff;
    logic signed [WORD_W-1:0] x;
    logic signed [WORD_W-1:0] y;
    logic signed [WORD_W-1:0] z;
  } pps_item_t;

  typedef struct packed {
    logic [DIM_W-1:0]         width;
    logic [DIM_W-1:0]         height;
    logic signed [WORD_W-1:0] center_u;
    logic signed [WORD_W-1:0] center_v;
    logic [FOCAL_W-1:0]       focal;
  } pps_cfg_t;

  typedef struct packed {
    logic valid;
    logic proj;
    logic wr;
  } pps_tag_t;

endpackage

/* rtl/pinhole_projection_sampler.sv */
// ----------------------------------------------------------------------------
// pinhole_projection_sampler: pinhole projection with nearest pixel sampling
// Loads an image and a pose, projects world points and samples the image.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_stall_o): each transfer carries one item.
// Pixel and pose loads give no result; ignored items are dropped at once.
// Each project item gives one result on the output channel
// (out_valid_o / out_stall_i), in order.
// Throughput is one item per cycle while the output is not stalled; items
// run through the 41-stage pipelined divider plus transform, rounding and
// image read stages.
// Items pass a four-entry queue, so input transfers continue while a
// result waits; a stalled output freezes the whole pipeline and the queue
// then fills and stalls the input.
// Configuration is written through cfg_we_i / cfg_index_i / cfg_data_i;
// the user must write it only while the block is idle, as the block itself does not enforce it.
// Reset restores the register defaults and empties the pipeline; image and
// pose contents are undefined until loaded.
// ----------------------------------------------------------------------------
module pinhole_projection_sampler #(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512,
  parameter int PIXEL_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [pps_pkg::FUNC_W-1:0]        func_i,
  input  logic [pps_pkg::IDX_W-1:0]         load_index_i,
  input  logic [pps_pkg::PIX_IN_W-1:0]      pixel_value_i,
  input  logic signed [pps_pkg::WORD_W-1:0] coeff_value_i,
  input  logic signed [pps_pkg::WORD_W-1:0] world_x_i,
  input  logic signed [pps_pkg::WORD_W-1:0] world_y_i,
  input  logic signed [pps_pkg::WORD_W-1:0] world_z_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [pps_pkg::PIX_IN_W-1:0]      intensity_o,
  output logic                              inside_res_o,
  output logic                              zero_depth_o,
  output logic [pps_pkg::OUT_IDX_W-1:0]     pixel_col_o,
  output logic [pps_pkg::OUT_IDX_W-1:0]     pixel_row_o,
  input  logic                              cfg_we_i,
  input  logic [pps_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [pps_pkg::WORD_W-1:0]        cfg_data_i
);
  import pps_pkg::*;

  pps_cfg_t  cfg_q;
  pps_item_t push_item, head_item;
  logic      push, full, head_valid, pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.width    <= RST_WIDTH;
      cfg_q.height   <= RST_HEIGHT;
      cfg_q.center_u <= '0;
      cfg_q.center_v <= '0;
      cfg_q.focal    <= RST_FOCAL;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_WIDTH:    cfg_q.width    <= cfg_data_i[DIM_W-1:0];
        CFG_HEIGHT:   cfg_q.height   <= cfg_data_i[DIM_W-1:0];
        CFG_CENTER_U: cfg_q.center_u <= cfg_data_i;
        CFG_CENTER_V: cfg_q.center_v <= cfg_data_i;
        CFG_FOCAL:    cfg_q.focal    <= cfg_data_i[FOCAL_W-1:0];
        default: ;
      endcase
    end
  end

  pps_front #(
    .STORE_DEPTH(MAX_WIDTH * MAX_HEIGHT)
  ) u_front (
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .func_i       (func_i),
    .load_index_i (load_index_i),
    .pixel_value_i(pixel_value_i),
    .coeff_value_i(coeff_value_i),
    .world_x_i    (world_x_i),
    .world_y_i    (world_y_i),
    .world_z_i    (world_z_i),
    .full_i       (full),
    .push_o       (push),
    .item_o       (push_item)
  );

  pps_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .item_i      (push_item),
    .full_o      (full),
    .head_valid_o(head_valid),
    .pop_i       (pop),
    .head_o      (head_item)
  );

  pps_back #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .PIXEL_BITS(PIXEL_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .head_valid_i(head_valid),
    .head_i      (head_item),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .intensity_o (intensity_o),
    .inside_res_o(inside_res_o),
    .zero_depth_o(zero_depth_o),
    .pixel_col_o (pixel_col_o),
    .pixel_row_o (pixel_row_o)
  );

endmodule

/* rtl/pps_front.sv */
// ----------------------------------------------------------------------------
// pps_front: input classification
// Accepts items, drops ignored ones and pushes the rest into the queue.
// ----------------------------------------------------------------------------
module pps_front #(
  parameter int STORE_DEPTH = 262144
) (
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [pps_pkg::FUNC_W-1:0]     func_i,
  input  logic [pps_pkg::IDX_W-1:0]      load_index_i,
  input  logic [pps_pkg::PIX_IN_W-1:0]   pixel_value_i,
  input  logic signed [pps_pkg::WORD_W-1:0] coeff_value_i,
  input  logic signed [pps_pkg::WORD_W-1:0] world_x_i,
  input  logic signed [pps_pkg::WORD_W-1:0] world_y_i,
  input  logic signed [pps_pkg::WORD_W-1:0] world_z_i,
  input  logic                           full_i,
  output logic                           push_o,
  output pps_pkg::pps_item_t             item_o
);
  import pps_pkg::*;

  logic keep;

  always_comb begin
    keep       = 1'b0;
    item_o.op  = OP_PROJECT;
    item_o.idx = load_index_i;
    item_o.pix = pixel_value_i;
    item_o.coeff = coeff_value_i;
    item_o.x   = world_x_i;
    item_o.y   = world_y_i;
    item_o.z   = world_z_i;
    case (func_i)
      FUNC_PIXEL: begin
        item_o.op = OP_PIXEL;
        keep      = 32'(load_index_i) < 32'(STORE_DEPTH);
      end
      FUNC_POSE: begin
        item_o.op = OP_POSE;
        keep      = 32'(load_index_i) < 32'(NUM_COEFFS);
      end
      FUNC_PROJECT: begin
        item_o.op = OP_PROJECT;
        keep      = 1'b1;
      end
      default: keep = 1'b0;
    endcase
  end

  assign in_stall_o = full_i;
  assign push_o     = in_valid_i && !full_i && keep;

endmodule

/* rtl/pps_queue.sv */
// ----------------------------------------------------------------------------
// pps_queue: item queue
// Small first-in first-out buffer between classification and execution.
// ----------------------------------------------------------------------------
module pps_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  pps_pkg::pps_item_t item_i,
  output logic               full_o,
  output logic               head_valid_o,
  input  logic               pop_i,
  output pps_pkg::pps_item_t head_o
);
  import pps_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  pps_item_t        mem_q [0:QUEUE_DEPTH-1];
  logic [PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [PTR_W:0]   cnt_q, cnt_d;

  always_comb begin
    wr_d  = push_i ? wr_q + 1'b1 : wr_q;
    rd_d  = pop_i ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + (PTR_W+1)'(push_i) - (PTR_W+1)'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= item_i;
    end
  end

  assign full_o       = cnt_q == (PTR_W+1)'(QUEUE_DEPTH);
  assign head_valid_o = cnt_q != '0;
  assign head_o       = mem_q[rd_q];

endmodule

/* rtl/pps_back.sv */
// ----------------------------------------------------------------------------
// pps_back: execution pipeline
// Pose update, camera transform, pipelined divide, rounding, image access.
// ----------------------------------------------------------------------------
module pps_back #(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512,
  parameter int PIXEL_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  pps_pkg::pps_cfg_t               cfg_i,
  input  logic                            head_valid_i,
  input  pps_pkg::pps_item_t              head_i,
  output logic                            pop_o,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [pps_pkg::PIX_IN_W-1:0]    intensity_o,
  output logic                            inside_res_o,
  output logic                            zero_depth_o,
  output logic [pps_pkg::OUT_IDX_W-1:0]   pixel_col_o,
  output logic [pps_pkg::OUT_IDX_W-1:0]   pixel_row_o
);
  import pps_pkg::*;

  localparam int DEPTH     = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int COL_W     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int ROW_W     = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int PRODW     = 64;
  localparam int CAM_W     = 50;
  localparam int MAG_W     = 49;
  localparam int LO_W      = 24;
  localparam int PP0_W     = FOCAL_W + LO_W;
  localparam int PP1_W     = FOCAL_W + MAG_W - LO_W;
  localparam int NUM_W     = 80;
  localparam int Q_W       = 41;
  localparam int QS_W      = 42;
  localparam int S_W       = 44;
  localparam int CV_W      = S_W - 16;
  localparam int DIV_STEPS = Q_W;
  localparam int ST_DIV    = 6;
  localparam int ST_CLAMP  = ST_DIV + DIV_STEPS + 1;
  localparam int ST_SUM    = ST_CLAMP + 1;
  localparam int ST_IN     = ST_SUM + 1;
  localparam int ST_ADDR   = ST_IN + 1;
  localparam int ST_MEM    = ST_ADDR + 1;
  localparam int NST       = ST_MEM + 1;

  localparam logic [Q_W-1:0]        Q_LIMIT  = Q_W'(64'h100_0000_0000);
  localparam logic signed [S_W-1:0] S_HALF   = S_W'(32768);
  localparam logic signed [S_W-1:0] S_MIN_IN = S_W'(-65535);

  logic en;
  logic pop;

  pps_tag_t                  tag_q [0:NST-1];
  logic [ADDR_W-1:0]         wa_q  [0:ST_ADDR];
  logic [PIXEL_BITS-1:0]     wp_q  [0:ST_ADDR];

  logic signed [WORD_W-1:0]  coeff_q [0:NUM_COEFFS-1];
  logic signed [WORD_W-1:0]  w0_q  [0:2];
  logic signed [PRODW-1:0]   prod_q [0:8];
  logic signed [WORD_W-1:0]  off_q [0:2];
  logic signed [CAM_W-1:0]   cam_q [0:2];
  logic [MAG_W-1:0]          mag_q [0:1];
  logic                      neg3_q [0:1];
  logic [MAG_W-1:0]          den3_q, den4_q, den5_q;
  logic                      zero3_q, zero4_q, zero5_q;
  logic [PP0_W-1:0]          pp0_q [0:1];
  logic [PP1_W-1:0]          pp1_q [0:1];
  logic                      neg4_q [0:1];
  logic [NUM_W-1:0]          num_q [0:1];
  logic                      neg5_q [0:1];

  logic [MAG_W-1:0]          drem_q [0:DIV_STEPS][0:1];
  logic [Q_W-1:0]            dq_q   [0:DIV_STEPS][0:1];
  logic [Q_W-1:0]            dn_q   [0:DIV_STEPS][0:1];
  logic                      dsat_q [0:DIV_STEPS][0:1];
  logic                      dneg_q [0:DIV_STEPS][0:1];
  logic [MAG_W-1:0]          dd_q   [0:DIV_STEPS];
  logic                      dzero_q [0:DIV_STEPS];

  logic signed [QS_W-1:0]    qs_q [0:1];
  logic                      zero48_q, zero49_q, zero50_q, zero51_q, zero52_q;
  logic signed [S_W-1:0]     s_q [0:1];
  logic                      in50_q, in51_q, in52_q;
  logic [COL_W-1:0]          col50_q, col51_q, col52_q;
  logic [ROW_W-1:0]          row50_q, row51_q, row52_q;
  logic [ADDR_W-1:0]         addr_q;
  logic [PIXEL_BITS-1:0]     mem_q [0:DEPTH-1];
  logic [PIXEL_BITS-1:0]     rd_q;

  logic                      out_valid_q;
  logic [PIX_IN_W-1:0]       int_q;
  logic                      inside_q, zero_q;
  logic [OUT_IDX_W-1:0]      col_q, row_q;

  logic [31:0]               w_lim, h_lim;
  logic [CV_W-1:0]           cvx [0:1];
  logic                      ok [0:1];

  assign en    = !out_valid_q || !out_stall_i;
  assign pop   = en && head_valid_i;
  assign pop_o = pop;

  always_comb begin
    w_lim = (32'(cfg_i.width) > 32'(MAX_WIDTH)) ? 32'(MAX_WIDTH) : 32'(cfg_i.width);
    h_lim = (32'(cfg_i.height) > 32'(MAX_HEIGHT)) ? 32'(MAX_HEIGHT) : 32'(cfg_i.height);
    for (int l = 0; l < 2; l++) begin
      cvx[l] = s_q[l][S_W-1] ? '0 : s_q[l][S_W-1:16];
      ok[l]  = (s_q[l] >= S_MIN_IN) && (32'(cvx[l]) < ((l == 0) ? w_lim : h_lim));
    end
  end

  // tags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NST; k++) begin
        tag_q[k] <= '0;
      end
    end else if (en) begin
      tag_q[0].valid <= pop;
      tag_q[0].proj  <= pop && (head_i.op == OP_PROJECT);
      tag_q[0].wr    <= pop && (head_i.op == OP_PIXEL);
      for (int k = 1; k < NST; k++) begin
        tag_q[k] <= tag_q[k-1];
      end
    end
  end

  // pose store and front stages
  always_ff @(posedge clk_i) begin
    if (pop && head_i.op == OP_POSE) begin
      coeff_q[head_i.idx[COEFF_IDX_W-1:0]] <= head_i.coeff;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      w0_q[0] <= head_i.x;
      w0_q[1] <= head_i.y;
      w0_q[2] <= head_i.z;
      wa_q[0] <= ADDR_W'(32'(head_i.idx));
      wp_q[0] <= PIXEL_BITS'(32'(head_i.pix));
      for (int k = 1; k <= ST_ADDR; k++) begin
        wa_q[k] <= wa_q[k-1];
        wp_q[k] <= wp_q[k-1];
      end
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod_q[r*3+c] <= coeff_q[r*4+c] * w0_q[c];
        end
        off_q[r] <= coeff_q[r*4+3];
      end
      for (int r = 0; r < 3; r++) begin
        cam_q[r] <= CAM_W'(prod_q[r*3] >>> 16) + CAM_W'(prod_q[r*3+1] >>> 16)
                  + CAM_W'(prod_q[r*3+2] >>> 16) + CAM_W'(off_q[r]);
      end
      for (int l = 0; l < 2; l++) begin
        mag_q[l]  <= MAG_W'(cam_q[l][CAM_W-1] ? -cam_q[l] : cam_q[l]);
        neg3_q[l] <= cam_q[l][CAM_W-1] ^ cam_q[2][CAM_W-1];
      end
      den3_q  <= MAG_W'(cam_q[2][CAM_W-1] ? -cam_q[2] : cam_q[2]);
      zero3_q <= cam_q[2] == '0;
      for (int l = 0; l < 2; l++) begin
        pp0_q[l]  <= PP0_W'(cfg_i.focal) * PP0_W'(mag_q[l][LO_W-1:0]);
        pp1_q[l]  <= PP1_W'(cfg_i.focal) * PP1_W'(mag_q[l][MAG_W-1:LO_W]);
        neg4_q[l] <= neg3_q[l];
      end
      den4_q  <= den3_q;
      zero4_q <= zero3_q;
      for (int l = 0; l < 2; l++) begin
        num_q[l]  <= NUM_W'(pp0_q[l]) + (NUM_W'(pp1_q[l]) << LO_W);
        neg5_q[l] <= neg4_q[l];
      end
      den5_q  <= den4_q;
      zero5_q <= zero4_q;
      for (int l = 0; l < 2; l++) begin
        dsat_q[0][l] <= MAG_W'(num_q[l][NUM_W-1:Q_W]) >= den5_q;
        drem_q[0][l] <= MAG_W'(num_q[l][NUM_W-1:Q_W]);
        dn_q[0][l]   <= num_q[l][Q_W-1:0];
        dq_q[0][l]   <= '0;
        dneg_q[0][l] <= neg5_q[l];
      end
      dd_q[0]    <= den5_q;
      dzero_q[0] <= zero5_q;
    end
  end

  // restoring divide, one quotient bit per stage
  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    logic [MAG_W:0] trial [0:1];
    logic           ge    [0:1];

    always_comb begin
      for (int l = 0; l < 2; l++) begin
        trial[l] = {drem_q[j][l], dn_q[j][l][Q_W-1]};
        ge[l]    = trial[l] >= {1'b0, dd_q[j]};
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        for (int l = 0; l < 2; l++) begin
          drem_q[j+1][l] <= ge[l] ? MAG_W'(trial[l] - {1'b0, dd_q[j]}) : MAG_W'(trial[l]);
          dq_q[j+1][l]   <= {dq_q[j][l][Q_W-2:0], ge[l]};
          dn_q[j+1][l]   <= {dn_q[j][l][Q_W-2:0], 1'b0};
          dsat_q[j+1][l] <= dsat_q[j][l];
          dneg_q[j+1][l] <= dneg_q[j][l];
        end
        dd_q[j+1]    <= dd_q[j];
        dzero_q[j+1] <= dzero_q[j];
      end
    end
  end

  // rounding, bounds and image access
  always_ff @(posedge clk_i) begin
    logic [Q_W-1:0] qf;
    if (en) begin
      for (int l = 0; l < 2; l++) begin
        qf = (dsat_q[DIV_STEPS][l] || dq_q[DIV_STEPS][l] > Q_LIMIT) ?
             Q_LIMIT : dq_q[DIV_STEPS][l];
        qs_q[l] <= dneg_q[DIV_STEPS][l] ? -QS_W'({1'b0, qf}) : QS_W'({1'b0, qf});
      end
      zero48_q <= dzero_q[DIV_STEPS];
      s_q[0]   <= S_W'(qs_q[0]) + S_W'(cfg_i.center_u) + S_HALF;
      s_q[1]   <= S_W'(qs_q[1]) + S_W'(cfg_i.center_v) + S_HALF;
      zero49_q <= zero48_q;
      in50_q   <= !zero49_q && ok[0] && ok[1];
      col50_q  <= cvx[0][COL_W-1:0];
      row50_q  <= cvx[1][ROW_W-1:0];
      zero50_q <= zero49_q;
      addr_q   <= ADDR_W'(32'(row50_q) + 32'(col50_q) * h_lim);
      in51_q   <= in50_q;
      col51_q  <= col50_q;
      row51_q  <= row50_q;
      zero51_q <= zero50_q;
      in52_q   <= in51_q;
      col52_q  <= col51_q;
      row52_q  <= row51_q;
      zero52_q <= zero51_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (tag_q[ST_ADDR].wr) begin
        mem_q[wa_q[ST_ADDR]] <= wp_q[ST_ADDR];
      end
      rd_q <= mem_q[addr_q];
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= tag_q[ST_MEM].valid && tag_q[ST_MEM].proj;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && tag_q[ST_MEM].proj) begin
      int_q    <= in52_q ? PIX_IN_W'(32'(rd_q)) : '0;
      inside_q <= in52_q;
      zero_q   <= zero52_q;
      col_q    <= in52_q ? OUT_IDX_W'(32'(col52_q)) : '0;
      row_q    <= in52_q ? OUT_IDX_W'(32'(row52_q)) : '0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign intensity_o  = int_q;
  assign inside_res_o = inside_q;
  assign zero_depth_o = zero_q;
  assign pixel_col_o  = col_q;
  assign pixel_row_o  = row_q;

endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb: testbench of the pinhole projection sampler
// Loads images and poses, projects world points under several camera
// settings, and compares each result with an in-bench fixed-point predictor.
// Both handshakes idle and stall at random; one long output hold-off fills
// the block until it stalls its input.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
  import pps_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_NONE = 2'd3;
  localparam int STORE_DEPTH = 512 * 512;
  localparam int DRAIN_CYCLES = 80;
  localparam int CYCLE_LIMIT = 600000;
  localparam longint Q_LIMIT = 64'h100_0000_0000;
  localparam logic signed [WORD_W-1:0] ONE = 32'sd65536;

  typedef struct {
    logic [PIX_IN_W-1:0]  intensity;
    logic                 in_image;
    logic                 zero;
    logic [OUT_IDX_W-1:0] col;
    logic [OUT_IDX_W-1:0] row;
    int                   addr;
  } sample_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     in_valid_i = 1'b0;
  logic                     in_stall_o;
  logic [FUNC_W-1:0]        func_i = FUNC_NONE;
  logic [IDX_W-1:0]         load_index_i = '0;
  logic [PIX_IN_W-1:0]      pixel_value_i = '0;
  logic signed [WORD_W-1:0] coeff_value_i = '0;
  logic signed [WORD_W-1:0] world_x_i = '0;
  logic signed [WORD_W-1:0] world_y_i = '0;
  logic signed [WORD_W-1:0] world_z_i = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic [PIX_IN_W-1:0]      intensity_o;
  logic                     inside_res_o;
  logic                     zero_depth_o;
  logic [OUT_IDX_W-1:0]     pixel_col_o;
  logic [OUT_IDX_W-1:0]     pixel_row_o;
  logic                     cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_index_i = '0;
  logic [WORD_W-1:0]        cfg_data_i = '0;

  // predictor state
  logic [PIX_IN_W-1:0]      image_mem [STORE_DEPTH];
  bit                       pixel_written [STORE_DEPTH];
  logic signed [WORD_W-1:0] pose_mem [NUM_COEFFS];
  int                       cur_width = 512;
  int                       cur_height = 512;
  longint                   cur_cu = 0;
  longint                   cur_cv = 0;
  longint                   cur_focal = 65536;

  sample_t samples_due[$];
  int      errors = 0;
  int      cycles = 0;
  bit      hold_req = 1'b0;
  bit      in_burst = 1'b0;
  bit      out_burst = 1'b0;

  pinhole_projection_sampler dut (.*);

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic int rand_gap();
    if ($urandom_range(0, 9) < 8) return $urandom_range(0, 2);
    return $urandom_range(5, 30);
  endfunction

  function automatic longint cam_coord(int r, logic signed [WORD_W-1:0] x,
                                       logic signed [WORD_W-1:0] y,
                                       logic signed [WORD_W-1:0] z);
    longint acc;
    acc = (longint'(pose_mem[r*4]) * longint'(x)) >>> 16;
    acc += (longint'(pose_mem[r*4+1]) * longint'(y)) >>> 16;
    acc += (longint'(pose_mem[r*4+2]) * longint'(z)) >>> 16;
    return acc + longint'(pose_mem[r*4+3]);
  endfunction

  function automatic longint scaled_ratio(longint num, longint den);
    logic [127:0] mag;
    logic [127:0] quot;
    longint       q;
    mag  = 128'(num < 0 ? -num : num) * 128'(cur_focal);
    quot = mag / 128'(den < 0 ? -den : den);
    q = (quot > 128'(Q_LIMIT)) ? Q_LIMIT : longint'(quot);
    return ((num < 0) != (den < 0)) ? -q : q;
  endfunction

  function automatic sample_t project_point(logic signed [WORD_W-1:0] x,
                                            logic signed [WORD_W-1:0] y,
                                            logic signed [WORD_W-1:0] z);
    sample_t s;
    longint  xc, yc, zc, col, row;
    int      w, h;
    s = '{intensity: '0, in_image: 1'b0, zero: 1'b0, col: '0, row: '0, addr: 0};
    xc = cam_coord(0, x, y, z);
    yc = cam_coord(1, x, y, z);
    zc = cam_coord(2, x, y, z);
    if (zc == 0) begin
      s.zero = 1'b1;
      return s;
    end
    col = (scaled_ratio(xc, zc) + cur_cu + 32768) / 65536;
    row = (scaled_ratio(yc, zc) + cur_cv + 32768) / 65536;
    w = cur_width > 512 ? 512 : cur_width;
    h = cur_height > 512 ? 512 : cur_height;
    if (col >= 0 && row >= 0 && col < w && row < h) begin
      s.addr = int'(row + col * h);
      s.in_image = 1'b1;
      s.intensity = image_mem[s.addr];
      s.col = col[OUT_IDX_W-1:0];
      s.row = row[OUT_IDX_W-1:0];
    end
    return s;
  endfunction

  task automatic send_item(logic [FUNC_W-1:0] f, logic [IDX_W-1:0] idx,
                           logic [PIX_IN_W-1:0] pix, logic signed [WORD_W-1:0] coeff,
                           logic signed [WORD_W-1:0] x, logic signed [WORD_W-1:0] y,
                           logic signed [WORD_W-1:0] z);
    int gap;
    gap = in_burst ? 0 : rand_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    func_i        <= f;
    load_index_i  <= idx;
    pixel_value_i <= pix;
    coeff_value_i <= coeff;
    world_x_i     <= x;
    world_y_i     <= y;
    world_z_i     <= z;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    case (f)
      FUNC_PIXEL: begin
        image_mem[idx] = pix;
        pixel_written[idx] = 1'b1;
      end
      FUNC_POSE: if (idx < NUM_COEFFS) pose_mem[idx[COEFF_IDX_W-1:0]] = coeff;
      FUNC_PROJECT: samples_due.push_back(project_point(x, y, z));
      default: ;
    endcase
  endtask

  task automatic load_pixel(int idx, logic [PIX_IN_W-1:0] pix);
    send_item(FUNC_PIXEL, IDX_W'(idx), pix, $urandom, $urandom, $urandom, $urandom);
  endtask

  task automatic load_coeff(logic [IDX_W-1:0] idx, logic signed [WORD_W-1:0] c);
    send_item(FUNC_POSE, idx, PIX_IN_W'($urandom), c, $urandom, $urandom, $urandom);
  endtask

  // first writes the target pixel if it was never loaded
  task automatic project(logic signed [WORD_W-1:0] x, logic signed [WORD_W-1:0] y,
                         logic signed [WORD_W-1:0] z);
    sample_t s;
    s = project_point(x, y, z);
    if (s.in_image && !pixel_written[s.addr]) load_pixel(s.addr, PIX_IN_W'($urandom));
    send_item(FUNC_PROJECT, IDX_W'($urandom), PIX_IN_W'($urandom), $urandom, x, y, z);
  endtask

  task automatic load_pose(bit noisy);
    for (int i = 0; i < NUM_COEFFS; i++) begin
      logic signed [WORD_W-1:0] c;
      c = (i % 5 == 0) ? ONE : 32'sd0;
      if (noisy) begin
        if (i % 4 == 3) c = $urandom_range(0, 40 * 65536) - 20 * 65536;
        else c = c + $urandom_range(0, 8192) - 4096;
      end
      load_coeff(IDX_W'(i), c);
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] data);
    in_valid_i <= 1'b0;
    while (samples_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_WIDTH:    cur_width = 32'(data[DIM_W-1:0]);
      CFG_HEIGHT:   cur_height = 32'(data[DIM_W-1:0]);
      CFG_CENTER_U: cur_cu = longint'(signed'(data));
      CFG_CENTER_V: cur_cv = longint'(signed'(data));
      CFG_FOCAL:    cur_focal = 64'(data[FOCAL_W-1:0]);
      default: ;
    endcase
  endtask

  task automatic aimed_point(int span);
    logic signed [WORD_W-1:0] z;
    z = ONE << $urandom_range(0, 3);
    project((($urandom_range(0, span) - 8) * z) + $urandom_range(0, 65535),
            (($urandom_range(0, span) - 8) * z) + $urandom_range(0, 65535), z);
  endtask

  task automatic test_directed();
    load_pose(1'b0);
    load_coeff(IDX_W'(12), $urandom);
    load_coeff({IDX_W{1'b1}}, $urandom);
    send_item(FUNC_NONE, IDX_W'($urandom), PIX_IN_W'($urandom), $urandom, ONE, ONE, ONE);
    project(32'sd0, 32'sd0, ONE);
    project(32'sd32767, 32'sd32768, ONE);
    project(-32'sd32768, -32'sd98303, ONE);
    project(511 * ONE, 511 * ONE, ONE);
    project(512 * ONE, 3 * ONE, ONE);
    project(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sd1);
    project(32'sh8000_0000, 32'sh7fff_ffff, -32'sd1);
    project(5 * ONE, 7 * ONE, 32'sd0);
    project(-5 * ONE, -7 * ONE, -ONE);
    project(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
    project(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff);
    load_pixel(STORE_DEPTH - 1, 16'hffff);
    load_pixel(0, 16'h0000);
  endtask

  task automatic test_config_extremes();
    write_reg(CFG_WIDTH, 1);
    write_reg(CFG_HEIGHT, 1);
    project(0, 0, ONE);
    project(ONE, 0, ONE);
    write_reg(CFG_WIDTH, 0);
    project(0, 0, ONE);
    write_reg(CFG_WIDTH, 1023);
    write_reg(CFG_HEIGHT, 1023);
    project(600 * ONE, 511 * ONE, ONE);
    write_reg(CFG_CENTER_U, 32'h7fff_ffff);
    write_reg(CFG_CENTER_V, 32'h8000_0000);
    project(0, 0, ONE);
    write_reg(CFG_CENTER_U, 32'h0000_8000);
    write_reg(CFG_CENTER_V, 100 << 16);
    write_reg(CFG_FOCAL, 0);
    project(9 * ONE, 9 * ONE, ONE);
    write_reg(CFG_FOCAL, 32'h7fff_ffff);
    project(32'sd1, 32'sd1, 32'sh7fff_ffff);
    project(ONE, -ONE, ONE);
  endtask

  task automatic test_backpressure();
    write_reg(CFG_FOCAL, 65536);
    write_reg(CFG_CENTER_U, 0);
    write_reg(CFG_CENTER_V, 0);
    in_burst = 1'b1;
    hold_req = 1'b1;
    for (int i = 0; i < 60; i++) aimed_point(40);
    in_burst = 1'b0;
  endtask

  task automatic test_random();
    for (int ph = 0; ph < 6; ph++) begin
      case ($urandom_range(0, 3))
        0: write_reg(CFG_WIDTH, 512);
        1: write_reg(CFG_WIDTH, $urandom_range(1, 1023));
        2: write_reg(CFG_WIDTH, $urandom);
        default: write_reg(CFG_WIDTH, $urandom_range(32, 200));
      endcase
      write_reg(CFG_HEIGHT, ph == 0 ? 512 : $urandom_range(1, 600));
      write_reg(CFG_CENTER_U, ph % 3 == 2 ? $urandom : $urandom_range(0, 64 << 16));
      write_reg(CFG_CENTER_V, ph % 3 == 2 ? $urandom : $urandom_range(0, 64 << 16));
      write_reg(CFG_FOCAL, ph % 3 == 1 ? $urandom : $urandom_range(32768, 131072));
      load_pose(ph != 0);
      in_burst = (ph == 3);
      out_burst = (ph == 4);
      for (int i = 0; i < 30; i++) begin
        case ($urandom_range(0, 9))
          0: project($urandom, $urandom, $urandom);
          1: load_coeff(IDX_W'($urandom_range(0, 15)),
                        $urandom_range(0, 2 * 65536) - 65536);
          2: send_item($urandom_range(0, 1) ? FUNC_NONE : FUNC_PIXEL,
                       IDX_W'($urandom), PIX_IN_W'($urandom), $urandom, $urandom,
                       $urandom, $urandom);
          default: aimed_point(260);
        endcase
      end
      in_burst = 1'b0;
      out_burst = 1'b0;
    end
  endtask

  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        hold_req = 1'b0;
        repeat (400) @(posedge clk_i);
      end else if (out_burst) begin
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= ($urandom_range(0, 9) < 3);
        if ($urandom_range(0, 40) == 0) repeat ($urandom_range(5, 30)) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (samples_due.size() == 0) begin
        $display("%0t: result transfer with none due", $time);
        errors++;
      end else begin
        sample_t e;
        e = samples_due.pop_front();
        if (intensity_o !== e.intensity || inside_res_o !== e.in_image ||
            zero_depth_o !== e.zero || pixel_col_o !== e.col || pixel_row_o !== e.row) begin
          $display("%0t: mismatch exp int %h in %b zd %b col %0d row %0d",
                   $time, e.intensity, e.in_image, e.zero, e.col, e.row);
          $display("%0t:          got int %h in %b zd %b col %0d row %0d",
                   $time, intensity_o, inside_res_o, zero_depth_o, pixel_col_o,
                   pixel_row_o);
          errors++;
        end
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_config_extremes();
    test_backpressure();
    test_random();
    in_valid_i <= 1'b0;
    while (samples_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
